// ===== src/tcce_pkg.sv =====
package tcce_pkg;

  // Screen geometry of the two text modes.
  localparam int WIDE_COLS   = 80;
  localparam int WIDE_ROWS   = 34;
  localparam int NARROW_COLS = 40;
  localparam int NARROW_ROWS = 17;

  localparam int AREA_WIDE    = WIDE_COLS * WIDE_ROWS;
  localparam int AREA_NARROW  = NARROW_COLS * NARROW_ROWS;
  localparam int SCREEN_DEPTH = (AREA_WIDE > AREA_NARROW) ? AREA_WIDE : AREA_NARROW;
  localparam int ADDR_W       = $clog2(SCREEN_DEPTH);
  localparam int CNT_W        = $clog2(SCREEN_DEPTH + 1);

  // Field widths.
  localparam int CMD_W  = 3;
  localparam int CHAR_W = 8;
  localparam int COL_W  = 7;
  localparam int ROW_W  = 6;
  localparam int IDX_W  = 12;
  localparam int DIMW_W = 8;
  localparam int DIMH_W = 7;

  // Commands.
  localparam logic [CMD_W-1:0] CMD_PUT   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_CR    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd2;
  localparam logic [CMD_W-1:0] CMD_HOME  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_SETC  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_READ  = 3'd5;

  // Control characters.
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0d;
  localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CH_UP    = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0a;
  localparam logic [CHAR_W-1:0] CH_ADV   = 8'h0b;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  // Text modes.
  localparam logic [1:0] MODE_NARROW = 2'd1;
  localparam logic [1:0] MODE_WIDE   = 2'd2;

  // Configuration register indexes.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_MODE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR = 1'b1;

endpackage

// ===== src/tcce_in_if.sv =====
interface tcce_in_if;
  import tcce_pkg::*;
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [CHAR_W-1:0] char_code;
  logic [COL_W-1:0]  col;
  logic [ROW_W-1:0]  row;
  logic [IDX_W-1:0]  cell_index;
  modport source (output valid, cmd, char_code, col, row, cell_index, input ready);
  modport sink (input valid, cmd, char_code, col, row, cell_index, output ready);
endinterface

// ===== src/tcce_out_if.sv =====
interface tcce_out_if;
  import tcce_pkg::*;
  logic              valid;
  logic              ready;
  logic [COL_W-1:0]  cursor_col;
  logic [ROW_W-1:0]  cursor_row;
  logic [CHAR_W-1:0] read_char;
  logic [CHAR_W-1:0] read_color;
  logic              scrolled;
  modport source (output valid, cursor_col, cursor_row, read_char, read_color, scrolled,
                  input ready);
  modport sink (input valid, cursor_col, cursor_row, read_char, read_color, scrolled,
                output ready);
endinterface

// ===== src/text_console_cursor_engine_core.sv =====
// Results: cursor-only commands and plain characters give their result beat in the cycle
// after acceptance; read cell passes through the READ state first; clear screen walks
// every cell of the mode's area; a scroll copies each row up and then blanks the last row.
// Throughput: one item at a time, next item accepted once the engine is idle and the result register is free.
// Reset: asynchronous active low; afterwards a clearing pass over all SCREEN_DEPTH cells
// zeroes the screen memory while no item is accepted (configuration writes are taken).
module text_console_cursor_engine_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [tcce_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tcce_pkg::CFG_DATA_W-1:0] cfg_data_i,
  tcce_in_if.sink                         in_ch,
  tcce_out_if.source                      out_ch
);
  import tcce_pkg::*;

  localparam logic [2:0] ST_CLR    = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_SCROLL = 3'd2;
  localparam logic [2:0] ST_BLANK  = 3'd3;
  localparam logic [2:0] ST_FILL   = 3'd4;
  localparam logic [2:0] ST_READ   = 3'd5;

  logic [2:0]        state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [COL_W-1:0]  cur_col_q, cur_col_d;
  logic [ROW_W-1:0]  cur_row_q, cur_row_d;
  logic [1:0]        mode_q;
  logic [CHAR_W-1:0] color_q;
  logic [CHAR_W-1:0] fill_q, fill_d;
  logic              pend_q, pend_d;
  logic [ADDR_W-1:0] pend_addr_q, pend_addr_d;
  logic              rd_zero_q, rd_zero_d;
  logic              scr_q, scr_d;

  logic              out_valid_q, out_valid_d;
  logic [COL_W-1:0]  out_col_q;
  logic [ROW_W-1:0]  out_row_q;
  logic [CHAR_W-1:0] out_char_q, out_color_q;
  logic              out_scr_q;
  logic              finish;
  logic [CHAR_W-1:0] fin_char, fin_color;

  // Screen memory, one write and one read port.
  logic [2*CHAR_W-1:0] mem [SCREEN_DEPTH];
  logic [2*CHAR_W-1:0] rdata_q, wdata;
  logic [ADDR_W-1:0]   waddr, raddr;
  logic                we;

  // Mode geometry.
  logic              text_on;
  logic [DIMW_W-1:0] w;
  logic [DIMH_W-1:0] h;
  logic [CNT_W-1:0]  area, scroll_n;

  logic accept;
  logic [DIMW_W-1:0] col_inc;
  logic [DIMH_W-1:0] row_nx;
  logic [DIMW_W-1:0] col_nx;
  logic              chk;
  logic [ADDR_W+2:0] cell_prod;

  always_comb begin
    unique case (mode_q)
      MODE_NARROW: begin
        text_on = 1'b1;
        w = DIMW_W'(NARROW_COLS);
        h = DIMH_W'(NARROW_ROWS);
        area = CNT_W'(AREA_NARROW);
        scroll_n = CNT_W'(AREA_NARROW - NARROW_COLS);
      end
      MODE_WIDE: begin
        text_on = 1'b1;
        w = DIMW_W'(WIDE_COLS);
        h = DIMH_W'(WIDE_ROWS);
        area = CNT_W'(AREA_WIDE);
        scroll_n = CNT_W'(AREA_WIDE - WIDE_COLS);
      end
      default: begin
        text_on = 1'b0;
        w = DIMW_W'(WIDE_COLS);
        h = DIMH_W'(WIDE_ROWS);
        area = CNT_W'(AREA_WIDE);
        scroll_n = CNT_W'(AREA_WIDE - WIDE_COLS);
      end
    endcase
  end

  assign in_ch.ready = (state_q == ST_IDLE) && (!out_valid_q || out_ch.ready);
  assign accept      = in_ch.valid && in_ch.ready;
  assign col_inc     = DIMW_W'(cur_col_q) + DIMW_W'(1);
  assign cell_prod   = (ADDR_W+3)'(cur_row_q) * (ADDR_W+3)'(w) + (ADDR_W+3)'(cur_col_q);

  // Command decode and the walk sequencer.
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    cur_col_d   = cur_col_q;
    cur_row_d   = cur_row_q;
    fill_d      = fill_q;
    pend_d      = 1'b0;
    pend_addr_d = pend_addr_q;
    rd_zero_d   = rd_zero_q;
    scr_d       = scr_q;
    finish      = 1'b0;
    fin_char    = '0;
    fin_color   = '0;
    we          = 1'b0;
    waddr       = '0;
    wdata       = '0;
    raddr       = '0;
    col_nx      = DIMW_W'(cur_col_q);
    row_nx      = DIMH_W'(cur_row_q);
    chk         = 1'b0;

    unique case (state_q)
      ST_CLR: begin
        we    = 1'b1;
        waddr = ADDR_W'(cnt_q);
        if (cnt_q == CNT_W'(SCREEN_DEPTH - 1)) begin
          state_d = ST_IDLE;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      ST_IDLE: begin
        if (accept) begin
          scr_d = 1'b0;
          unique case (in_ch.cmd)
            CMD_PUT: begin
              if (text_on) begin
                unique case (in_ch.char_code)
                  CH_CR: begin
                    col_nx = '0;
                    row_nx = DIMH_W'(cur_row_q) + DIMH_W'(1);
                    chk    = 1'b1;
                  end
                  CH_BS: begin
                    if (cur_col_q != '0) begin
                      col_nx = DIMW_W'(cur_col_q) - DIMW_W'(1);
                    end else if (cur_row_q != '0) begin
                      row_nx = DIMH_W'(cur_row_q) - DIMH_W'(1);
                      col_nx = w - DIMW_W'(1);
                    end
                  end
                  CH_UP: begin
                    if (cur_row_q != '0) begin
                      row_nx = DIMH_W'(cur_row_q) - DIMH_W'(1);
                    end
                  end
                  CH_LF: begin
                    row_nx = DIMH_W'(cur_row_q) + DIMH_W'(1);
                    chk    = 1'b1;
                  end
                  default: begin
                    if (in_ch.char_code != CH_ADV) begin
                      we    = 1'b1;
                      waddr = ADDR_W'(cell_prod);
                      wdata = {color_q, in_ch.char_code};
                    end
                    if (col_inc >= w) begin
                      col_nx = '0;
                      row_nx = DIMH_W'(cur_row_q) + DIMH_W'(1);
                      chk    = 1'b1;
                    end else begin
                      col_nx = col_inc;
                    end
                  end
                endcase
              end
            end
            CMD_CR: begin
              col_nx = '0;
              if (text_on) begin
                row_nx = DIMH_W'(cur_row_q) + DIMH_W'(1);
                chk    = 1'b1;
              end
            end
            CMD_CLEAR: begin
              if (text_on) begin
                state_d = ST_FILL;
                cnt_d   = '0;
                fill_d  = in_ch.char_code;
              end
            end
            CMD_HOME: begin
              col_nx = '0;
              row_nx = '0;
            end
            CMD_SETC: begin
              col_nx = (DIMW_W'(in_ch.col) > w - DIMW_W'(1)) ? w - DIMW_W'(1)
                                                             : DIMW_W'(in_ch.col);
              row_nx = (DIMH_W'(in_ch.row) > h - DIMH_W'(1)) ? h - DIMH_W'(1)
                                                             : DIMH_W'(in_ch.row);
            end
            CMD_READ: begin
              state_d   = ST_READ;
              raddr     = ADDR_W'(in_ch.cell_index);
              rd_zero_d = (CNT_W+1)'(in_ch.cell_index) >= (CNT_W+1)'(SCREEN_DEPTH);
            end
            default: ;
          endcase

          // A row that ran past the bottom scrolls the screen.
          if (chk && (row_nx >= h)) begin
            row_nx  = h - DIMH_W'(1);
            scr_d   = 1'b1;
            state_d = ST_SCROLL;
            cnt_d   = '0;
          end
          cur_col_d = COL_W'(col_nx);
          cur_row_d = ROW_W'(row_nx);
          if (state_d == ST_IDLE) begin
            finish = 1'b1;
          end
        end
      end
      ST_SCROLL: begin
        // Read one row below, write it back in the next cycle.
        if (pend_q) begin
          we    = 1'b1;
          waddr = pend_addr_q;
          wdata = rdata_q;
        end
        if (cnt_q < scroll_n) begin
          raddr       = ADDR_W'(cnt_q + CNT_W'(w));
          pend_d      = 1'b1;
          pend_addr_d = ADDR_W'(cnt_q);
          cnt_d       = cnt_q + CNT_W'(1);
        end else begin
          state_d = ST_BLANK;
        end
      end
      ST_BLANK: begin
        we    = 1'b1;
        waddr = ADDR_W'(cnt_q);
        wdata = {color_q, CH_SPACE};
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == area - CNT_W'(1)) begin
          state_d = ST_IDLE;
          finish  = 1'b1;
        end
      end
      ST_FILL: begin
        we    = 1'b1;
        waddr = ADDR_W'(cnt_q);
        wdata = {color_q, fill_q};
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == area - CNT_W'(1)) begin
          state_d = ST_IDLE;
          finish  = 1'b1;
        end
      end
      ST_READ: begin
        state_d = ST_IDLE;
        finish  = 1'b1;
        if (!rd_zero_q) begin
          fin_char  = rdata_q[CHAR_W-1:0];
          fin_color = rdata_q[2*CHAR_W-1:CHAR_W];
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // Writing a text mode homes the cursor.
    if (cfg_we_i && (cfg_idx_i == REG_MODE) &&
        ((cfg_data_i[1:0] == MODE_NARROW) || (cfg_data_i[1:0] == MODE_WIDE))) begin
      cur_col_d = '0;
      cur_row_d = '0;
    end
  end

  // Result register handshake.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ch.ready) begin
      out_valid_d = 1'b0;
    end
    if (finish) begin
      out_valid_d = 1'b1;
    end
  end

  // Screen memory ports.
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr];
  end

  // Control state and cursor.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      cnt_q       <= '0;
      cur_col_q   <= '0;
      cur_row_q   <= '0;
      mode_q      <= MODE_NARROW;
      color_q     <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
      cur_col_q   <= cur_col_d;
      cur_row_q   <= cur_row_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_MODE) begin
          mode_q <= cfg_data_i[1:0];
        end else begin
          color_q <= cfg_data_i;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    fill_q      <= fill_d;
    pend_addr_q <= pend_addr_d;
    rd_zero_q   <= rd_zero_d;
    scr_q       <= scr_d;
    if (finish) begin
      out_col_q   <= cur_col_d;
      out_row_q   <= cur_row_d;
      out_char_q  <= fin_char;
      out_color_q <= fin_color;
      out_scr_q   <= scr_d;
    end
  end

  assign out_ch.valid      = out_valid_q;
  assign out_ch.cursor_col = out_col_q;
  assign out_ch.cursor_row = out_row_q;
  assign out_ch.read_char  = out_char_q;
  assign out_ch.read_color = out_color_q;
  assign out_ch.scrolled   = out_scr_q;

endmodule

// ===== src/tcce_checker.sv =====
module tcce_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_i,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic [tcce_pkg::COL_W-1:0]   cursor_col_i,
  input logic [tcce_pkg::ROW_W-1:0]   cursor_row_i
);
  import tcce_pkg::*;

  // A stalled result beat stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result beat dropped while stalled");

  // No new beat is taken while a result waits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |-> !in_ready_i)
    else $error("input taken while result stalled");

  // The reported cursor stays inside the largest screen.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (cursor_col_i < COL_W'(WIDE_COLS)) && (cursor_row_i < ROW_W'(WIDE_ROWS)))
    else $error("cursor out of bounds");

endmodule

bind text_console_cursor_engine_core tcce_checker u_tcce_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_ch.valid),
  .in_ready_i   (in_ch.ready),
  .out_valid_i  (out_ch.valid),
  .out_ready_i  (out_ch.ready),
  .cursor_col_i (out_ch.cursor_col),
  .cursor_row_i (out_ch.cursor_row)
);

// ===== dv/text_console_cursor_engine_core_checker.sv =====
module text_console_cursor_engine_core_checker
  import tcce_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  tcce_in_if.sink  in_mon,
  tcce_out_if.sink out_mon,
  output int fail_count_o,
  output int pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [COL_W-1:0]  cursor_col;
    logic [ROW_W-1:0]  cursor_row;
    logic [CHAR_W-1:0] read_char;
    logic [CHAR_W-1:0] read_color;
    logic              scrolled;
  } cursor_report_t;

  logic [15:0] screen_mirror [SCREEN_DEPTH];
  int unsigned cur_col, cur_row;
  logic [1:0] mode_q;
  logic [7:0] color_q;
  cursor_report_t report_queue[$];
  int mismatches;

  assign fail_count_o = mismatches;
  assign pending_o = report_queue.size();

  // Store one cell with the current color.
  function automatic void write_cell(int unsigned idx, logic [7:0] ch);
    if (idx < SCREEN_DEPTH) screen_mirror[idx] = {color_q, ch};
  endfunction

  // Scroll up once the row has run past the last row.
  function automatic bit wrap_screen(int unsigned w, int unsigned h);
    if (cur_row < h) return 0;
    cur_row = h - 1;
    for (int unsigned i = 0; i < w * (h - 1); i++)
      if (i + w < SCREEN_DEPTH) screen_mirror[i] = screen_mirror[i + w];
    for (int unsigned i = w * (h - 1); i < w * h; i++) write_cell(i, CH_SPACE);
    return 1;
  endfunction

  function automatic bit step_cursor(int unsigned w, int unsigned h);
    cur_col++;
    if (cur_col >= w) begin
      cur_col = 0;
      cur_row++;
      return wrap_screen(w, h);
    end
    return 0;
  endfunction

  // Work out the report for one accepted command beat.
  function automatic cursor_report_t apply_command(logic [CMD_W-1:0] cmd, logic [7:0] ch,
                                                   logic [COL_W-1:0] c, logic [ROW_W-1:0] r,
                                                   logic [IDX_W-1:0] idx);
    cursor_report_t rep;
    int unsigned w, h;
    bit text;
    rep = '0;
    text = (mode_q == MODE_NARROW) || (mode_q == MODE_WIDE);
    w = (mode_q == MODE_NARROW) ? NARROW_COLS : WIDE_COLS;
    h = (mode_q == MODE_NARROW) ? NARROW_ROWS : WIDE_ROWS;
    case (cmd)
      CMD_PUT: if (text) begin
        case (ch)
          CH_CR: begin
            cur_col = 0;
            cur_row++;
            rep.scrolled = wrap_screen(w, h);
          end
          CH_BS: begin
            if (cur_col != 0) cur_col--;
            else if (cur_row != 0) begin
              cur_row--;
              cur_col = w - 1;
            end
          end
          CH_UP: if (cur_row != 0) cur_row--;
          CH_LF: begin
            cur_row++;
            rep.scrolled = wrap_screen(w, h);
          end
          CH_ADV: rep.scrolled = step_cursor(w, h);
          default: begin
            write_cell(cur_row * w + cur_col, ch);
            rep.scrolled = step_cursor(w, h);
          end
        endcase
      end
      CMD_CR: begin
        if (text) begin
          cur_col = 0;
          cur_row++;
          rep.scrolled = wrap_screen(w, h);
        end else begin
          cur_col = 0;
        end
      end
      CMD_CLEAR: if (text) for (int unsigned i = 0; i < w * h; i++) write_cell(i, ch);
      CMD_HOME: begin
        cur_col = 0;
        cur_row = 0;
      end
      CMD_SETC: begin
        cur_col = (c > w - 1) ? w - 1 : c;
        cur_row = (r > h - 1) ? h - 1 : r;
      end
      CMD_READ: if (idx < SCREEN_DEPTH) {rep.read_color, rep.read_char} = screen_mirror[idx];
      default: ;
    endcase
    rep.cursor_col = cur_col[COL_W-1:0];
    rep.cursor_row = cur_row[ROW_W-1:0];
    return rep;
  endfunction

  // Follow configuration writes and both channels at the rising edge.
  always @(posedge clk_i or negedge rst_ni) begin
    cursor_report_t seen, want;
    if (!rst_ni) begin
      foreach (screen_mirror[i]) screen_mirror[i] = '0;
      cur_col = 0;
      cur_row = 0;
      mode_q = MODE_NARROW;
      color_q = '0;
      mismatches = 0;
      report_queue.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_MODE) begin
          mode_q = cfg_data_i[1:0];
          if (mode_q == MODE_NARROW || mode_q == MODE_WIDE) begin
            cur_col = 0;
            cur_row = 0;
          end
        end else begin
          color_q = cfg_data_i;
        end
      end
      if (out_mon.valid && out_mon.ready) begin
        seen = '{out_mon.cursor_col, out_mon.cursor_row, out_mon.read_char,
                 out_mon.read_color, out_mon.scrolled};
        if (report_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat %p", seen);
        end else begin
          want = report_queue.pop_front();
          if (seen !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, seen);
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        report_queue.push_back(apply_command(in_mon.cmd, in_mon.char_code, in_mon.col,
                                             in_mon.row, in_mon.cell_index));
    end
  end
endmodule

// ===== dv/text_console_cursor_engine_core_test.sv =====
module text_console_cursor_engine_core_test;
  import tcce_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  int fail_count, pending;
  int idle_pct = 35;

  tcce_in_if  cmd_ch ();
  tcce_out_if rsp_ch ();

  text_console_cursor_engine_core uut (
    .clk_i, .rst_ni, .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_ch(cmd_ch), .out_ch(rsp_ch)
  );

  text_console_cursor_engine_core_checker checker_i (
    .clk_i, .rst_ni, .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_mon(cmd_ch), .out_mon(rsp_ch), .fail_count_o(fail_count), .pending_o(pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Hard stop; a full run with many scrolls stays well inside this.
  initial begin
    #200ms;
    $display("text_console_cursor_engine_core_test: errors");
    $finish;
  end

  // The result side stalls at random at the falling edge.
  always @(negedge clk_i) rsp_ch.ready <= ($urandom_range(99) >= idle_pct);

  // Send one command beat and wait for it to be taken; valid stays up for a
  // following beat and drops only while idling.
  task automatic send_cmd(logic [CMD_W-1:0] cmd, logic [7:0] ch, logic [COL_W-1:0] c,
                          logic [ROW_W-1:0] r, logic [IDX_W-1:0] idx);
    while ($urandom_range(99) < idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.cmd <= cmd;
    cmd_ch.char_code <= ch;
    cmd_ch.col <= c;
    cmd_ch.row <= r;
    cmd_ch.cell_index <= idx;
    do @(posedge clk_i); while (!cmd_ch.ready);
    @(negedge clk_i);
  endtask

  // Write a register once all results are back and the block has settled.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] data);
    cmd_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (3000) @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // Random command mix, mostly text with some control codes, cursor moves, reads, clears and undefined commands.
  task automatic random_cmd();
    logic [7:0] ch;
    int pick;
    pick = $urandom_range(99);
    ch = CHAR_W'($urandom);
    if ($urandom_range(3) == 0) ch = CH_BS + CHAR_W'($urandom_range(5));
    if (pick < 55) send_cmd(CMD_PUT, ch, COL_W'($urandom), ROW_W'($urandom), IDX_W'($urandom));
    else if (pick < 60)
      send_cmd(CMD_CR, ch, COL_W'($urandom), ROW_W'($urandom), IDX_W'($urandom));
    else if (pick < 61)
      send_cmd(CMD_CLEAR, ch, COL_W'($urandom), ROW_W'($urandom), IDX_W'($urandom));
    else if (pick < 64)
      send_cmd(CMD_HOME, ch, COL_W'($urandom), ROW_W'($urandom), IDX_W'($urandom));
    else if (pick < 74)
      send_cmd(CMD_SETC, ch, COL_W'($urandom), ROW_W'($urandom), IDX_W'($urandom));
    else if (pick < 96)
      send_cmd(CMD_READ, ch, COL_W'($urandom), ROW_W'($urandom),
               ($urandom_range(9) == 0) ? IDX_W'($urandom) : IDX_W'($urandom_range(2719)));
    else send_cmd(CMD_W'($urandom_range(6, 7)), ch, COL_W'($urandom), ROW_W'($urandom),
                  IDX_W'($urandom));
  endtask

  initial begin
    cfg_we = 1'b0;
    cfg_idx = REG_MODE;
    cfg_data = '0;
    cmd_ch.valid = 1'b0;
    cmd_ch.cmd = CMD_PUT;
    cmd_ch.char_code = '0;
    cmd_ch.col = '0;
    cmd_ch.row = '0;
    cmd_ch.cell_index = '0;
    rsp_ch.ready = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: reads after reset, control codes, saturation, scroll at the last row.
    write_reg(REG_COLOR, 8'hff);
    send_cmd(CMD_READ, 8'h00, '0, '0, 12'd0);
    send_cmd(CMD_PUT, CH_BS, '0, '0, '0);
    send_cmd(CMD_PUT, CH_UP, '0, '0, '0);
    send_cmd(CMD_PUT, 8'hff, '0, '0, '0);
    send_cmd(CMD_PUT, CH_BS, '0, '0, '0);
    send_cmd(CMD_READ, 8'h00, '0, '0, 12'd0);
    send_cmd(CMD_SETC, 8'h00, 7'h7f, 6'h3f, '0);
    send_cmd(CMD_PUT, 8'h41, '0, '0, '0);
    send_cmd(CMD_READ, 8'h00, '0, '0, 12'd679);
    send_cmd(CMD_PUT, CH_LF, '0, '0, '0);
    send_cmd(CMD_PUT, CH_CR, '0, '0, '0);
    send_cmd(CMD_PUT, CH_ADV, '0, '0, '0);
    send_cmd(CMD_PUT, CH_BS, '0, '0, '0);
    send_cmd(CMD_CR, 8'h00, '0, '0, '0);
    send_cmd(CMD_READ, 8'h00, '0, '0, 12'hfff);
    send_cmd(CMD_CLEAR, 8'h2a, '0, '0, '0);
    send_cmd(CMD_READ, 8'h00, '0, '0, 12'd2719);
    send_cmd(CMD_HOME, 8'h00, '0, '0, '0);
    send_cmd(3'd6, 8'h00, '0, '0, '0);
    send_cmd(3'd7, 8'h00, '0, '0, '0);
    write_reg(REG_MODE, 8'd0);
    send_cmd(CMD_PUT, 8'h55, '0, '0, '0);
    send_cmd(CMD_CLEAR, 8'h55, '0, '0, '0);
    send_cmd(CMD_SETC, 8'h00, 7'h7f, 6'h3f, '0);
    send_cmd(CMD_CR, 8'h00, '0, '0, '0);

    // Random phases across all modes and colors, extremes included.
    for (int phase = 0; phase < 8; phase++) begin
      write_reg(REG_MODE, (phase == 7) ? 8'd3 : 8'(phase % 3));
      write_reg(REG_COLOR, (phase == 0) ? 8'h00 : (phase == 1) ? 8'hff : 8'($urandom));
      idle_pct = (phase == 4) ? 0 : 35;
      for (int n = 0; n < 190; n++) random_cmd();
    end

    cmd_ch.valid <= 1'b0;
    idle_pct = 0;
    while (pending != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("text_console_cursor_engine_core_test: clean");
    end else begin
      $display("text_console_cursor_engine_core_test: errors");
    end
    $finish;
  end
endmodule
